// ----- rtl/dlpt_pkg.sv -----
// ----------------------------------------------------------------------------
// dlpt_pkg
// Shared types and codes of the DHCP lease pool table: operation, status and
// reply codes, register indexes, configuration bundle and table entry.
// ----------------------------------------------------------------------------
package dlpt_pkg;

  localparam int MacW      = 48;
  localparam int IpW       = 32;
  localparam int SizeW     = 9;
  localparam int SlotOutW  = 8;
  localparam int ApbAddrW  = 4;
  localparam int ApbDataW  = 32;

  typedef enum logic [1:0] {
    OP_DISCOVER = 2'd0,
    OP_REQUEST  = 2'd1,
    OP_INFORM   = 2'd2,
    OP_RELEASE  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    STS_EXISTING  = 3'd0,
    STS_ASSIGNED  = 3'd1,
    STS_EXHAUSTED = 3'd2,
    STS_RELEASED  = 3'd3,
    STS_UNKNOWN   = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    REPLY_NONE  = 2'd0,
    REPLY_OFFER = 2'd1,
    REPLY_ACK   = 2'd2
  } reply_e;

  typedef enum logic [1:0] {
    REG_POOL_START = 2'd0,
    REG_POOL_SIZE  = 2'd1,
    REG_RESERVED   = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic [IpW-1:0]   pool_start_ip;
    logic [SizeW-1:0] pool_size;
    logic [SizeW-1:0] reserved_slot;
  } cfg_t;

  typedef struct packed {
    logic            used;
    logic [MacW-1:0] mac;
  } entry_t;

endpackage

// ----- rtl/dhcp_lease_pool_table.sv -----
// The result strobe on done_o is registered from the DONE state, which follows
// the slot-by-slot scan through the single read port of the lease memory; a
// new start is taken only in idle, so one transaction is handled at a time.
// Reset: a clearing pass frees every slot; busy stays high
// until it ends. Configuration writes are taken at all times.
// The receiver cannot stall: each result is shown for one cycle on done_o.
// ----------------------------------------------------------------------------
// dhcp_lease_pool_table
// Lease table of a DHCP address pool: lookup, allocation and release of
// pool slots by client MAC.
// ----------------------------------------------------------------------------
module dhcp_lease_pool_table
  import dlpt_pkg::*;
#(
  parameter int POOL_MAX = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          operation_i,
  input  logic [MacW-1:0]     client_mac_i,
  output logic                done_o,
  output logic [2:0]          status_o,
  output logic [1:0]          reply_kind_o,
  output logic [SlotOutW-1:0] slot_o,
  output logic [IpW-1:0]      assigned_ip_o
);

  localparam int SlotW = $clog2(POOL_MAX);

  cfg_t             cfg;
  logic             mem_we;
  logic [SlotW-1:0] mem_waddr;
  entry_t           mem_wdata;
  logic             mem_re;
  logic [SlotW-1:0] mem_raddr;
  entry_t           mem_rdata;

  dlpt_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  dlpt_lease_mem #(
    .Depth (POOL_MAX),
    .AddrW (SlotW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  dlpt_scan_ctrl #(
    .PoolMax (POOL_MAX),
    .SlotW   (SlotW)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .start_i       (start),
    .operation_i   (operation_i),
    .client_mac_i  (client_mac_i),
    .busy_o        (busy),
    .done_o        (done_o),
    .status_o      (status_o),
    .reply_kind_o  (reply_kind_o),
    .slot_o        (slot_o),
    .assigned_ip_o (assigned_ip_o),
    .mem_we_o      (mem_we),
    .mem_waddr_o   (mem_waddr),
    .mem_wdata_o   (mem_wdata),
    .mem_re_o      (mem_re),
    .mem_raddr_o   (mem_raddr),
    .mem_rdata_i   (mem_rdata)
  );

endmodule

// ----- rtl/dlpt_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// dlpt_cfg_regs
// APB register file: pool start address, pool size and reserved slot.
// ----------------------------------------------------------------------------
module dlpt_cfg_regs
  import dlpt_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready,
  output cfg_t                cfg_o
);

  cfg_t     cfg_q;
  logic     wr_en;
  reg_idx_e idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_e'(paddr[3:2]);
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pool_start_ip <= '0;
      cfg_q.pool_size     <= SizeW'(256);
      cfg_q.reserved_slot <= SizeW'(256);
    end else if (wr_en) begin
      unique case (idx)
        REG_POOL_START: cfg_q.pool_start_ip <= pwdata;
        REG_POOL_SIZE:  cfg_q.pool_size     <= pwdata[SizeW-1:0];
        REG_RESERVED:   cfg_q.reserved_slot <= pwdata[SizeW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_POOL_START: prdata = cfg_q.pool_start_ip;
      REG_POOL_SIZE:  prdata = ApbDataW'(cfg_q.pool_size);
      REG_RESERVED:   prdata = ApbDataW'(cfg_q.reserved_slot);
      default:        prdata = '0;
    endcase
  end

endmodule

// ----- rtl/dlpt_lease_mem.sv -----
// ----------------------------------------------------------------------------
// dlpt_lease_mem
// Lease table memory: one used flag and one client MAC per slot, one write
// port and one read port with registered read data.
// ----------------------------------------------------------------------------
module dlpt_lease_mem
  import dlpt_pkg::*;
#(
  parameter int Depth = 256,
  parameter int AddrW = 8
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  entry_t           wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output entry_t           rdata_o
);

  entry_t mem [Depth];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/dlpt_scan_ctrl.sv -----
// ----------------------------------------------------------------------------
// dlpt_scan_ctrl
// Sequencer: clears the table after reset, scans every slot for the client
// MAC and the lowest free slot, then issues the result and any write-back.
// ----------------------------------------------------------------------------
module dlpt_scan_ctrl
  import dlpt_pkg::*;
#(
  parameter int PoolMax = 256,
  parameter int SlotW   = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cfg_t                cfg_i,
  input  logic                start_i,
  input  logic [1:0]          operation_i,
  input  logic [MacW-1:0]     client_mac_i,
  output logic                busy_o,
  output logic                done_o,
  output logic [2:0]          status_o,
  output logic [1:0]          reply_kind_o,
  output logic [SlotOutW-1:0] slot_o,
  output logic [IpW-1:0]      assigned_ip_o,
  output logic                mem_we_o,
  output logic [SlotW-1:0]    mem_waddr_o,
  output entry_t              mem_wdata_o,
  output logic                mem_re_o,
  output logic [SlotW-1:0]    mem_raddr_o,
  input  entry_t              mem_rdata_i
);

  localparam int CntW = SlotW + 1;
  localparam int CmpW = (CntW > SizeW) ? CntW : SizeW;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_e;

  state_e               state_q, state_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic                 chk_vld_q, chk_vld_d;
  logic [SlotW-1:0]     chk_addr_q, chk_addr_d;
  op_e                  op_q, op_d;
  logic [MacW-1:0]      mac_q, mac_d;
  logic                 match_q, match_d;
  logic [SlotW-1:0]     match_slot_q, match_slot_d;
  logic                 free_q, free_d;
  logic [SlotW-1:0]     free_slot_q, free_slot_d;
  logic                 done_q, done_d;
  status_e              status_q, status_d;
  reply_e               kind_q, kind_d;
  logic [SlotOutW-1:0]  slot_q, slot_d;
  logic [IpW-1:0]       ip_q, ip_d;

  logic                 issuing;
  logic                 hit_now;
  logic                 free_now;
  reply_e               grant_kind;

  assign issuing  = cnt_q < CntW'(PoolMax);
  assign hit_now  = mem_rdata_i.used && (mem_rdata_i.mac == mac_q);
  assign free_now = !mem_rdata_i.used
                    && (CmpW'(chk_addr_q) < CmpW'(cfg_i.pool_size))
                    && (CmpW'(chk_addr_q) != CmpW'(cfg_i.reserved_slot));
  assign grant_kind = (op_q == OP_DISCOVER) ? REPLY_OFFER : REPLY_ACK;

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    chk_vld_d    = chk_vld_q;
    chk_addr_d   = chk_addr_q;
    op_d         = op_q;
    mac_d        = mac_q;
    match_d      = match_q;
    match_slot_d = match_slot_q;
    free_d       = free_q;
    free_slot_d  = free_slot_q;
    done_d       = 1'b0;
    status_d     = status_q;
    kind_d       = kind_q;
    slot_d       = slot_q;
    ip_d         = ip_q;
    mem_we_o     = 1'b0;
    mem_waddr_o  = cnt_q[SlotW-1:0];
    mem_wdata_o  = '0;
    mem_re_o     = 1'b0;
    mem_raddr_o  = cnt_q[SlotW-1:0];

    unique case (state_q)
      ST_CLEAR: begin
        // sweep the table once, marking every slot free
        mem_we_o = 1'b1;
        cnt_d    = cnt_q + 1'b1;
        if (cnt_q == CntW'(PoolMax - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start_i) begin
          op_d      = op_e'(operation_i);
          mac_d     = client_mac_i;
          cnt_d     = '0;
          chk_vld_d = 1'b0;
          match_d   = 1'b0;
          free_d    = 1'b0;
          state_d   = ST_SCAN;
        end
      end
      ST_SCAN: begin
        mem_re_o   = issuing;
        chk_vld_d  = issuing;
        chk_addr_d = cnt_q[SlotW-1:0];
        if (issuing) begin
          cnt_d = cnt_q + 1'b1;
        end
        // keep only the lowest hit and the lowest free slot
        if (chk_vld_q) begin
          if (hit_now && !match_q) begin
            match_d      = 1'b1;
            match_slot_d = chk_addr_q;
          end
          if (free_now && !free_q) begin
            free_d      = 1'b1;
            free_slot_d = chk_addr_q;
          end
        end
        if (!issuing && chk_vld_q) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        state_d  = ST_IDLE;
        done_d   = 1'b1;
        status_d = STS_EXHAUSTED;
        kind_d   = REPLY_NONE;
        slot_d   = '0;
        ip_d     = '0;
        if (op_q == OP_RELEASE) begin
          if (match_q) begin
            status_d         = STS_RELEASED;
            slot_d           = SlotOutW'(match_slot_q);
            ip_d             = cfg_i.pool_start_ip + IpW'(match_slot_q);
            mem_we_o         = 1'b1;
            mem_waddr_o      = match_slot_q;
            mem_wdata_o.used = 1'b0;
            mem_wdata_o.mac  = mac_q;
          end else begin
            status_d = STS_UNKNOWN;
          end
        end else if (match_q) begin
          status_d = STS_EXISTING;
          kind_d   = grant_kind;
          slot_d   = SlotOutW'(match_slot_q);
          ip_d     = cfg_i.pool_start_ip + IpW'(match_slot_q);
        end else if (free_q) begin
          status_d         = STS_ASSIGNED;
          kind_d           = grant_kind;
          slot_d           = SlotOutW'(free_slot_q);
          ip_d             = cfg_i.pool_start_ip + IpW'(free_slot_q);
          mem_we_o         = 1'b1;
          mem_waddr_o      = free_slot_q;
          mem_wdata_o.used = 1'b1;
          mem_wdata_o.mac  = mac_q;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      cnt_q        <= '0;
      chk_vld_q    <= 1'b0;
      chk_addr_q   <= '0;
      op_q         <= OP_DISCOVER;
      mac_q        <= '0;
      match_q      <= 1'b0;
      match_slot_q <= '0;
      free_q       <= 1'b0;
      free_slot_q  <= '0;
      done_q       <= 1'b0;
      status_q     <= STS_EXISTING;
      kind_q       <= REPLY_NONE;
      slot_q       <= '0;
      ip_q         <= '0;
    end else begin
      state_q      <= state_d;
      cnt_q        <= cnt_d;
      chk_vld_q    <= chk_vld_d;
      chk_addr_q   <= chk_addr_d;
      op_q         <= op_d;
      mac_q        <= mac_d;
      match_q      <= match_d;
      match_slot_q <= match_slot_d;
      free_q       <= free_d;
      free_slot_q  <= free_slot_d;
      done_q       <= done_d;
      status_q     <= status_d;
      kind_q       <= kind_d;
      slot_q       <= slot_d;
      ip_q         <= ip_d;
    end
  end

  assign busy_o        = (state_q != ST_IDLE);
  assign done_o        = done_q;
  assign status_o      = status_q;
  assign reply_kind_o  = kind_q;
  assign slot_o        = slot_q;
  assign assigned_ip_o = ip_q;

endmodule

// ----- rtl/dlpt_checker.sv -----
// ----------------------------------------------------------------------------
// dlpt_checker
// Port-level checks of the lease pool table, bound to the top level.
// ----------------------------------------------------------------------------
module dlpt_checker
  import dlpt_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                start,
  input logic                busy,
  input logic                done_o,
  input logic [2:0]          status_o,
  input logic [1:0]          reply_kind_o,
  input logic [SlotOutW-1:0] slot_o,
  input logic [IpW-1:0]      assigned_ip_o
);

  // an accepted transaction occupies the block in the next cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("busy not raised after an accepted transaction");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while busy");

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

  a_exhausted_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (status_o == STS_EXHAUSTED) |->
      (reply_kind_o == REPLY_NONE) && (slot_o == '0) && (assigned_ip_o == '0))
    else $error("exhausted pool result carries a lease");

  a_release_noreply: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && ((status_o == STS_RELEASED) || (status_o == STS_UNKNOWN)) |->
      (reply_kind_o == REPLY_NONE))
    else $error("release result carries a reply");

endmodule

bind dhcp_lease_pool_table dlpt_checker u_dlpt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start         (start),
  .busy          (busy),
  .done_o        (done_o),
  .status_o      (status_o),
  .reply_kind_o  (reply_kind_o),
  .slot_o        (slot_o),
  .assigned_ip_o (assigned_ip_o)
);
